// File: design/tarp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarp_pkg: shared types and constants of the two anchor position unit
// Register indexes, payload types and the cell widths.
// ----------------------------------------------------------------------------
package tarp_pkg;

    localparam int DIVW = 48;   // remainder bits of a division cell
    localparam int SQR  = 17;   // root bits

    localparam logic [1:0] REG_DIST = 2'd0;
    localparam logic [1:0] REG_CALA = 2'd1;
    localparam logic [1:0] REG_CALB = 2'd2;

    typedef struct packed {
        logic [31:0] rss_first;
        logic [31:0] rss_second;
    } t_in;

    typedef struct packed {
        logic [15:0] x_pos;
        logic signed [23:0] y_pos;
        logic [31:0] range_sq_first;
        logic [31:0] range_sq_second;
        logic        clamped;
        logic        status;
    } t_out;

endpackage
`default_nettype wire

// File: design/tarp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarp_if: valid/ready channel
// Carries one payload per transaction.
// ----------------------------------------------------------------------------
interface tarp_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/tarp_divcell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarp_divcell: one restoring division step
// Shifts in one numerator bit and conditionally subtracts the divisor.
// ----------------------------------------------------------------------------
module tarp_divcell (
    input  wire logic [tarp_pkg::DIVW-1:0] i_rem,
    input  wire logic                      i_bit,
    input  wire logic [tarp_pkg::DIVW-1:0] i_den,
    output logic [tarp_pkg::DIVW-1:0]      o_rem,
    output logic                           o_q
);
    logic [tarp_pkg::DIVW:0] w_t;
    always_comb begin
        w_t = {i_rem, i_bit};
        if (w_t >= {1'b0, i_den}) begin
            o_q   = 1'b1;
            w_t   = w_t - {1'b0, i_den};
        end else begin
            o_q = 1'b0;
        end
        o_rem = w_t[tarp_pkg::DIVW-1:0];
    end
endmodule
`default_nettype wire

// File: design/tarp_sqcell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tarp_sqcell: one digit of a restoring square root
// Brings down two radicand bits and tries the next root bit.
// ----------------------------------------------------------------------------
module tarp_sqcell (
    input  wire logic [tarp_pkg::SQR+1:0] i_rem,
    input  wire logic [tarp_pkg::SQR-1:0] i_root,
    input  wire logic [1:0]               i_bits,
    output logic [tarp_pkg::SQR+1:0]      o_rem,
    output logic [tarp_pkg::SQR-1:0]      o_root
);
    logic [tarp_pkg::SQR+3:0] w_t;
    logic [tarp_pkg::SQR+3:0] w_try;
    logic [tarp_pkg::SQR+3:0] w_diff;
    always_comb begin
        w_t    = {i_rem, i_bits};
        w_try  = {2'b00, i_root, 2'b01};
        w_diff = w_t - w_try;
        if (w_t >= w_try) begin
            o_rem  = w_diff[tarp_pkg::SQR+1:0];
            o_root = {i_root[tarp_pkg::SQR-2:0], 1'b1};
        end else begin
            o_rem  = w_t[tarp_pkg::SQR+1:0];
            o_root = {i_root[tarp_pkg::SQR-2:0], 1'b0};
        end
    end
endmodule
`default_nettype wire

// File: design/two_anchor_rss_position_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_anchor_rss_position_unit: 2D position from two anchor strengths
// Fully pipelined chain of divider and square root cells.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one pair of linear strengths per
// transaction; the output channel returns one result per transaction.
// Registers are written through a plain write port (index 0 distance,
// 1 and 2 calibration constants); the user must write them only while the
// unit is idle, which the block does not enforce. The datapath is a row of
// cells, one division or root step each: an input register, 64 cells for
// the two range divisions, a saturation register, a y numerator register,
// 49 cells for y, two registers for saturating and squaring y, one for the
// clamp, 17 root cells and the output register. One transaction is accepted
// every cycle while the output is not stalled. The pipeline advances only
// when the last stage is empty or being taken, so a stalled receiver freezes
// the whole chain and input ready falls; nothing is lost. Reset empties the
// pipeline and restores the registers (distance 1.0 m, constants zero).
// ----------------------------------------------------------------------------
module two_anchor_rss_position_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [47:0] i_cfg_data,
    tarp_if.sink             s_in,
    tarp_if.source           m_out
);
    localparam int NA = 64;           // range division cells
    localparam int NB = 49;           // y division cells
    localparam int NC = 17;           // root cells
    localparam int L  = NA + NB + NC + 7;

    logic [15:0] r_dist;
    logic [47:0] r_cala, r_calb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= 16'd256;
            r_cala <= '0;
            r_calb <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tarp_pkg::REG_DIST: r_dist <= i_cfg_data[15:0];
                tarp_pkg::REG_CALA: r_cala <= i_cfg_data;
                tarp_pkg::REG_CALB: r_calb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_v [L];
    logic w_en;
    assign w_en = !r_v[L-1] || m_out.ready;
    assign s_in.ready = w_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= s_in.valid;
            for (int k = 1; k < L; k++) r_v[k] <= r_v[k-1];
        end
    end

    // ---------------- stage A: range divisions (cal << 16) / rss
    logic [47:0] r_ar1 [NA+1], r_ar2 [NA+1];
    logic [63:0] r_aq1 [NA+1], r_aq2 [NA+1];
    logic [63:0] r_an1 [NA+1], r_an2 [NA+1];
    logic [31:0] r_ad1 [NA+1], r_ad2 [NA+1];
    logic        r_az  [NA+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ar1[0] <= '0; r_ar2[0] <= '0; r_aq1[0] <= '0; r_aq2[0] <= '0;
            r_an1[0] <= {r_cala, 16'd0}; r_an2[0] <= {r_calb, 16'd0};
            r_ad1[0] <= s_in.data.rss_first; r_ad2[0] <= s_in.data.rss_second;
            r_az[0]  <= (s_in.data.rss_first == '0) || (s_in.data.rss_second == '0);
        end
    end
    for (genvar g = 0; g < NA; g++) begin : g_a
        logic [47:0] w_r1, w_r2;
        logic        w_q1, w_q2;
        tarp_divcell u_d1 (.i_rem(r_ar1[g]), .i_bit(r_an1[g][63]),
            .i_den({16'd0, r_ad1[g]}), .o_rem(w_r1), .o_q(w_q1));
        tarp_divcell u_d2 (.i_rem(r_ar2[g]), .i_bit(r_an2[g][63]),
            .i_den({16'd0, r_ad2[g]}), .o_rem(w_r2), .o_q(w_q2));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ar1[g+1] <= w_r1; r_ar2[g+1] <= w_r2;
                r_aq1[g+1] <= {r_aq1[g][62:0], w_q1};
                r_aq2[g+1] <= {r_aq2[g][62:0], w_q2};
                r_an1[g+1] <= {r_an1[g][62:0], 1'b0};
                r_an2[g+1] <= {r_an2[g][62:0], 1'b0};
                r_ad1[g+1] <= r_ad1[g]; r_ad2[g+1] <= r_ad2[g];
                r_az[g+1]  <= r_az[g];
            end
        end
    end

    // A quotient that needs more than 32 bits saturates the squared range.
    logic [31:0] r_r1, r_r2, r_dd;
    logic        r_z;
    logic [15:0] r_d;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1 <= (r_aq1[NA][63:32] != '0) ? 32'hFFFF_FFFF : r_aq1[NA][31:0];
            r_r2 <= (r_aq2[NA][63:32] != '0) ? 32'hFFFF_FFFF : r_aq2[NA][31:0];
            r_z  <= r_az[NA];
            r_d  <= r_dist;
            r_dd <= r_dist * r_dist;
        end
    end

    // ---------------- stage B: y = floor(num / den), num signed
    logic [47:0] r_br [NB+1], r_bq [NB+1];
    logic [48:0] r_bn [NB+1];
    logic [39:0] r_bd [NB+1];
    logic        r_bs [NB+1], r_bz [NB+1], r_bdz [NB+1];
    logic [31:0] r_b1 [NB+1], r_b2 [NB+1];
    always_ff @(posedge i_clk) begin
        logic signed [49:0] num;
        if (w_en) begin
            num = $signed({18'd0, r_r1} << 16) - $signed({18'd0, r_r2} << 16)
                + $signed({18'd0, r_dd} << 16);
            r_bs[0] <= num[49];
            r_bd[0] <= {7'd0, r_d, 17'd0};
            // For a negative numerator ~num is |num| - 1, so adding the divisor
            // gives |num| + den - 1 and the quotient rounds away from zero.
            r_bn[0] <= num[49] ? 49'(~num) + 49'({r_d, 17'd0}) : 49'(num);
            r_br[0] <= '0; r_bq[0] <= '0;
            r_bz[0] <= r_z; r_bdz[0] <= (r_d == '0);
            r_b1[0] <= r_r1; r_b2[0] <= r_r2;
        end
    end
    for (genvar g = 0; g < NB; g++) begin : g_b
        logic [47:0] w_r;
        logic        w_q;
        tarp_divcell u_d (.i_rem(r_br[g]), .i_bit(r_bn[g][48]),
            .i_den({8'd0, r_bd[g]}), .o_rem(w_r), .o_q(w_q));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_br[g+1] <= w_r; r_bq[g+1] <= {r_bq[g][46:0], w_q};
                r_bn[g+1] <= {r_bn[g][47:0], 1'b0};
                r_bd[g+1] <= r_bd[g]; r_bs[g+1] <= r_bs[g];
                r_bz[g+1] <= r_bz[g]; r_bdz[g+1] <= r_bdz[g];
                r_b1[g+1] <= r_b1[g]; r_b2[g+1] <= r_b2[g];
            end
        end
    end

    // ---------------- stage D storage, loaded by the clamp stage
    logic [tarp_pkg::SQR+1:0] r_sr [NC+1];
    logic [tarp_pkg::SQR-1:0] r_sq [NC+1];
    logic [33:0]              r_sv [NC+1];
    logic signed [23:0]       r_sy [NC+1];
    logic [31:0]              r_s1 [NC+1], r_s2 [NC+1];
    logic                     r_sz [NC+1], r_sc [NC+1];

    // ---------------- stage C: saturate y, square, subtract
    logic signed [23:0] r_cy, r_ey;
    logic [31:0] r_c1, r_c2, r_e1, r_e2;
    logic        r_cz, r_ez;
    logic [47:0] r_ey2;
    always_ff @(posedge i_clk) begin
        logic [47:0] q;
        logic [23:0] ya;
        if (w_en) begin
            q = r_bq[NB];
            if (r_bdz[NB])                    r_cy <= '0;
            else if (!r_bs[NB]) r_cy <= (q > 48'd8388607) ? 24'sd8388607 : 24'(q);
            else                r_cy <= (q > 48'd8388608) ? 24'sh800000 : 24'(-q);
            r_c1 <= r_b1[NB]; r_c2 <= r_b2[NB]; r_cz <= r_bz[NB];
            ya = r_cy[23] ? 24'(-r_cy) : 24'(r_cy);
            r_ey  <= r_cy;
            r_ey2 <= ya * ya;
            r_e1 <= r_c1; r_e2 <= r_c2; r_ez <= r_cz;
            r_sr[0] <= '0; r_sq[0] <= '0;
            r_sy[0] <= r_ey; r_s1[0] <= r_e1; r_s2[0] <= r_e2; r_sz[0] <= r_ez;
            if ({16'd0, r_e1} < r_ey2) begin
                r_sv[0] <= '0; r_sc[0] <= 1'b1;
            end else begin
                r_sv[0] <= 34'({16'd0, r_e1} - r_ey2); r_sc[0] <= 1'b0;
            end
        end
    end

    // ---------------- stage D: square root cells
    for (genvar g = 0; g < NC; g++) begin : g_s
        logic [tarp_pkg::SQR+1:0] w_r;
        logic [tarp_pkg::SQR-1:0] w_q;
        tarp_sqcell u_s (.i_rem(r_sr[g]), .i_root(r_sq[g]),
            .i_bits(r_sv[g][33:32]), .o_rem(w_r), .o_root(w_q));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sr[g+1] <= w_r; r_sq[g+1] <= w_q;
                r_sv[g+1] <= {r_sv[g][31:0], 2'b00};
                r_sy[g+1] <= r_sy[g]; r_s1[g+1] <= r_s1[g]; r_s2[g+1] <= r_s2[g];
                r_sz[g+1] <= r_sz[g]; r_sc[g+1] <= r_sc[g];
            end
        end
    end

    tarp_pkg::t_out r_out;
    always_ff @(posedge i_clk) begin
        tarp_pkg::t_out n_out;
        if (w_en) begin
            n_out = '0;
            if (r_sz[NC]) begin
                n_out.status = 1'b1;
            end else begin
                n_out.x_pos = r_sq[NC][16] ? 16'hFFFF : r_sq[NC][15:0];
                n_out.y_pos = r_sy[NC];
                n_out.range_sq_first  = r_s1[NC];
                n_out.range_sq_second = r_s2[NC];
                n_out.clamped = r_sc[NC];
                n_out.status  = 1'b0;
            end
            r_out <= n_out;
        end
    end
    assign m_out.valid = r_v[L-1];
    assign m_out.data  = r_out;
endmodule
`default_nettype wire
